@@ sv/serial_interface_register_block_top_assert.svh @@
// assertion macros for the serial interface register block
// clocked on i_clk, quiet while i_rst_n is low; used by the top level
`ifndef SERIAL_INTERFACE_REGISTER_BLOCK_TOP_ASSERT_SVH
`define SERIAL_INTERFACE_REGISTER_BLOCK_TOP_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define SIRB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence that holds in the cycle after the antecedent
`define SIRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sirb_pkg.sv @@
// shared types, constants and small tables for the serial interface register block
// no dependencies; used by sirb_decode, sirb_regs and the top level
`timescale 1ns / 1ps

package sirb_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int BUFFER_BYTES = 128;
    localparam int BUF_WORDS    = BUFFER_BYTES / 4;
    localparam int BUF_AW       = $clog2(BUF_WORDS);
    localparam int CH_CNT_W     = 3;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 56;

    localparam logic [9:0] OFF_POLL  = 10'h030;
    localparam logic [9:0] OFF_CSR   = 10'h034;
    localparam logic [9:0] OFF_STAT  = 10'h038;
    localparam logic [9:0] OFF_CLK   = 10'h03C;
    localparam logic [3:0] CHAN_WORDS = 4'd12;

    localparam logic [31:0] UNKNOWN_WORD = 32'hDEADBEEF;
    localparam logic [31:0] BUF_RESET    = 32'hCECECECE;

    // control/status bit positions
    localparam int CSR_TSTART_B     = 0;
    localparam int CSR_RDSTINTMSK_B = 27;
    localparam int CSR_RDSTINT_B    = 28;
    localparam int CSR_COMERR_B     = 29;
    localparam int CSR_TCINTMSK_B   = 30;
    localparam int CSR_TCINT_B      = 31;
    localparam logic [31:0] CSR_KEEP   = 32'h9000_0000;
    localparam logic [31:0] CSR_FIELDS = 32'h487F_7F06;

    // status word masks
    localparam logic [31:0] STAT_KEEP  = 32'h3030_3030;
    localparam logic [31:0] STAT_ERR   = 32'h0F0F_0F0F;
    localparam logic [31:0] STAT_WRST  = 32'h1010_1010;
    localparam logic [31:0] STAT_RDST  = 32'h2020_2020;
    localparam int          STAT_WR_B  = 31;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_DEV   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_kind;

    typedef enum logic [3:0] {
        TGT_NONE,
        TGT_DEV,
        TGT_BUF,
        TGT_CHAN,
        TGT_POLL,
        TGT_CSR,
        TGT_STAT,
        TGT_CLK,
        TGT_BAD
    } t_target;

    typedef enum logic [1:0] {
        KIND_OUT,
        KIND_IN_HI,
        KIND_IN_LO
    } t_chan_kind;

    typedef struct packed {
        t_req_kind   req_type;
        logic [9:0]  reg_offset;
        logic [31:0] write_data;
        logic [1:0]  dev_channel;
        logic        dev_has_data;
        logic [31:0] dev_in_hi;
        logic [31:0] dev_in_lo;
    } t_sirb_req;

    typedef struct packed {
        logic [1:0] chan;
        t_chan_kind kind;
    } t_chan_sel;

    typedef struct packed {
        t_target           target;
        logic              is_wr;
        logic [1:0]        chan;
        t_chan_kind        kind;
        logic [BUF_AW-1:0] buf_idx;
    } t_sirb_dec;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
        logic        send_commands;
        logic        transfer_start;
        logic [1:0]  transfer_channel;
        logic [7:0]  transfer_in_length;
        logic [7:0]  transfer_out_length;
    } t_sirb_res;

    typedef struct packed {
        logic rdstint;
        logic rdst_any;
        logic csr_stuck_bits;
    } t_sirb_mon;

    // word index 0..11 of the channel area to channel and word kind
    function automatic t_chan_sel word_to_chan(input logic [3:0] w);
        t_chan_sel s;
        s = '{chan: 2'd0, kind: KIND_OUT};
        case (w)
            4'd0:    s = '{chan: 2'd0, kind: KIND_OUT};
            4'd1:    s = '{chan: 2'd0, kind: KIND_IN_HI};
            4'd2:    s = '{chan: 2'd0, kind: KIND_IN_LO};
            4'd3:    s = '{chan: 2'd1, kind: KIND_OUT};
            4'd4:    s = '{chan: 2'd1, kind: KIND_IN_HI};
            4'd5:    s = '{chan: 2'd1, kind: KIND_IN_LO};
            4'd6:    s = '{chan: 2'd2, kind: KIND_OUT};
            4'd7:    s = '{chan: 2'd2, kind: KIND_IN_HI};
            4'd8:    s = '{chan: 2'd2, kind: KIND_IN_LO};
            4'd9:    s = '{chan: 2'd3, kind: KIND_OUT};
            4'd10:   s = '{chan: 2'd3, kind: KIND_IN_HI};
            4'd11:   s = '{chan: 2'd3, kind: KIND_IN_LO};
            default: s = '{chan: 2'd0, kind: KIND_OUT};
        endcase
        return s;
    endfunction

    // channel n keeps its flags in byte 3-n, rdst is bit 5 of that byte
    function automatic logic [4:0] rdst_pos(input logic [1:0] ch);
        logic [4:0] p;
        case (ch)
            2'd0:    p = 5'd29;
            2'd1:    p = 5'd21;
            2'd2:    p = 5'd13;
            2'd3:    p = 5'd5;
            default: p = 5'd5;
        endcase
        return p;
    endfunction

    // transfer length field, zero stands for the full 128 bytes
    function automatic logic [7:0] len_of(input logic [6:0] f);
        return (f == 7'd0) ? 8'd128 : ({1'b0, f} + 8'd1);
    endfunction

endpackage

@@ sv/sirb_decode.sv @@
// offset and request decode for the serial interface register block
// depends on sirb_pkg
`timescale 1ns / 1ps

module sirb_decode (
    input  sirb_pkg::t_sirb_req i_req,
    output sirb_pkg::t_sirb_dec o_dec
);

    sirb_pkg::t_chan_sel w_sel;
    logic [9:0]          w_off;
    logic                w_chan_area;

    assign w_off       = i_req.reg_offset;
    assign w_sel       = sirb_pkg::word_to_chan(w_off[5:2]);
    // aligned word in 0x00..0x2c
    assign w_chan_area = (w_off[9:6] == 4'd0) && (w_off[1:0] == 2'b00)
                         && (w_off[5:2] < sirb_pkg::CHAN_WORDS);

    always_comb begin
        o_dec.target  = sirb_pkg::TGT_NONE;
        o_dec.is_wr   = (i_req.req_type == sirb_pkg::REQ_WRITE);
        o_dec.chan    = w_sel.chan;
        o_dec.kind    = w_sel.kind;
        o_dec.buf_idx = w_off[sirb_pkg::BUF_AW+1:2];
        case (i_req.req_type)
            sirb_pkg::REQ_DEV: begin
                o_dec.chan = i_req.dev_channel;
                if ({1'b0, i_req.dev_channel} < sirb_pkg::CH_CNT_W'(sirb_pkg::NUM_CHANNELS)) begin
                    o_dec.target = sirb_pkg::TGT_DEV;
                end
            end
            sirb_pkg::REQ_READ, sirb_pkg::REQ_WRITE: begin
                if (w_off[9:7] == 3'b001) begin
                    o_dec.target = sirb_pkg::TGT_BUF;
                end else if (w_chan_area) begin
                    if ({1'b0, w_sel.chan} < sirb_pkg::CH_CNT_W'(sirb_pkg::NUM_CHANNELS)) begin
                        o_dec.target = sirb_pkg::TGT_CHAN;
                    end else begin
                        o_dec.target = sirb_pkg::TGT_BAD;
                    end
                end else if (w_off == sirb_pkg::OFF_POLL) begin
                    o_dec.target = sirb_pkg::TGT_POLL;
                end else if (w_off == sirb_pkg::OFF_CSR) begin
                    o_dec.target = sirb_pkg::TGT_CSR;
                end else if (w_off == sirb_pkg::OFF_STAT) begin
                    o_dec.target = sirb_pkg::TGT_STAT;
                end else if (w_off == sirb_pkg::OFF_CLK) begin
                    o_dec.target = sirb_pkg::TGT_CLK;
                end else begin
                    o_dec.target = sirb_pkg::TGT_BAD;
                end
            end
            default: begin
                o_dec.target = sirb_pkg::TGT_NONE;
            end
        endcase
    end

endmodule

@@ sv/sirb_regs.sv @@
// register file, transfer buffer and result logic of the serial interface register block
// depends on sirb_pkg; fed by sirb_decode
`timescale 1ns / 1ps

module sirb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  sirb_pkg::t_sirb_req i_req,
    input  sirb_pkg::t_sirb_dec i_dec,
    output sirb_pkg::t_sirb_res o_res,
    output sirb_pkg::t_sirb_mon o_mon
);

    logic [31:0] r_chan_out [sirb_pkg::NUM_CHANNELS];
    logic [31:0] r_chan_hi  [sirb_pkg::NUM_CHANNELS];
    logic [31:0] r_chan_lo  [sirb_pkg::NUM_CHANNELS];
    logic [31:0] r_buf      [sirb_pkg::BUF_WORDS];
    logic [31:0] r_poll, n_poll;
    logic [31:0] r_csr, n_csr;
    logic [31:0] r_status, n_status;
    logic [31:0] r_clk_cnt, n_clk_cnt;

    logic        w_buf_we, w_out_we, w_hi_we, w_lo_we, w_recompute;
    logic [31:0] w_hi_data, w_lo_data, w_wd;

    assign w_wd = i_req.write_data;

    always_comb begin
        n_poll      = r_poll;
        n_csr       = r_csr;
        n_status    = r_status;
        n_clk_cnt   = r_clk_cnt;
        w_buf_we    = 1'b0;
        w_out_we    = 1'b0;
        w_hi_we     = 1'b0;
        w_lo_we     = 1'b0;
        w_hi_data   = w_wd;
        w_lo_data   = w_wd;
        w_recompute = 1'b0;
        o_res       = '0;
        case (i_dec.target)
            sirb_pkg::TGT_DEV: begin
                w_hi_we     = 1'b1;
                w_lo_we     = 1'b1;
                w_hi_data   = i_req.dev_in_hi;
                w_lo_data   = i_req.dev_in_lo;
                n_status[sirb_pkg::rdst_pos(i_dec.chan)] = i_req.dev_has_data;
                w_recompute = 1'b1;
            end
            sirb_pkg::TGT_BUF: begin
                if (i_dec.is_wr) begin
                    w_buf_we = 1'b1;
                end else begin
                    o_res.read_data = r_buf[i_dec.buf_idx];
                end
            end
            sirb_pkg::TGT_CHAN: begin
                case (i_dec.kind)
                    sirb_pkg::KIND_OUT: begin
                        w_out_we        = i_dec.is_wr;
                        o_res.read_data = i_dec.is_wr ? 32'd0 : r_chan_out[i_dec.chan];
                    end
                    sirb_pkg::KIND_IN_HI: begin
                        w_hi_we = i_dec.is_wr;
                        if (!i_dec.is_wr) begin
                            // reading an input word consumes the data
                            n_status[sirb_pkg::rdst_pos(i_dec.chan)] = 1'b0;
                            w_recompute     = 1'b1;
                            o_res.read_data = r_chan_hi[i_dec.chan];
                        end
                    end
                    sirb_pkg::KIND_IN_LO: begin
                        w_lo_we = i_dec.is_wr;
                        if (!i_dec.is_wr) begin
                            n_status[sirb_pkg::rdst_pos(i_dec.chan)] = 1'b0;
                            w_recompute     = 1'b1;
                            o_res.read_data = r_chan_lo[i_dec.chan];
                        end
                    end
                    default: begin
                        w_out_we = 1'b0;
                    end
                endcase
            end
            sirb_pkg::TGT_POLL: begin
                if (i_dec.is_wr) begin
                    n_poll = w_wd;
                end else begin
                    o_res.read_data = r_poll;
                end
            end
            sirb_pkg::TGT_CSR: begin
                if (i_dec.is_wr) begin
                    n_csr = (r_csr & sirb_pkg::CSR_KEEP) | (w_wd & sirb_pkg::CSR_FIELDS);
                    // interrupt flags clear where one is written
                    if (w_wd[sirb_pkg::CSR_RDSTINT_B]) begin
                        n_csr[sirb_pkg::CSR_RDSTINT_B] = 1'b0;
                    end
                    if (w_wd[sirb_pkg::CSR_TCINT_B]) begin
                        n_csr[sirb_pkg::CSR_TCINT_B] = 1'b0;
                    end
                    if (w_wd[sirb_pkg::CSR_TSTART_B]) begin
                        o_res.transfer_start      = 1'b1;
                        o_res.transfer_channel    = n_csr[2:1];
                        o_res.transfer_in_length  = sirb_pkg::len_of(n_csr[14:8]);
                        o_res.transfer_out_length = sirb_pkg::len_of(n_csr[22:16]);
                        n_csr[sirb_pkg::CSR_TCINT_B] = 1'b1;
                    end
                    w_recompute = 1'b1;
                end else begin
                    o_res.read_data = r_csr;
                end
            end
            sirb_pkg::TGT_STAT: begin
                if (i_dec.is_wr) begin
                    n_status = (r_status & sirb_pkg::STAT_KEEP) | (w_wd & sirb_pkg::STAT_ERR);
                    if (w_wd[sirb_pkg::STAT_WR_B]) begin
                        o_res.send_commands = 1'b1;
                        n_status = n_status & ~sirb_pkg::STAT_WRST;
                    end
                end else begin
                    o_res.read_data = r_status;
                end
            end
            sirb_pkg::TGT_CLK: begin
                if (i_dec.is_wr) begin
                    n_clk_cnt = w_wd;
                end else begin
                    o_res.read_data = r_clk_cnt;
                end
            end
            sirb_pkg::TGT_BAD: begin
                if (!i_dec.is_wr) begin
                    o_res.read_data = sirb_pkg::UNKNOWN_WORD;
                end
            end
            default: begin
                o_res.read_data = 32'd0;
            end
        endcase
        if (w_recompute) begin
            n_csr[sirb_pkg::CSR_RDSTINT_B] = |(n_status & sirb_pkg::STAT_RDST);
        end
        o_res.irq = (n_csr[sirb_pkg::CSR_RDSTINT_B] & n_csr[sirb_pkg::CSR_RDSTINTMSK_B])
                  | (n_csr[sirb_pkg::CSR_TCINT_B] & n_csr[sirb_pkg::CSR_TCINTMSK_B]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll    <= '0;
            r_csr     <= '0;
            r_status  <= '0;
            r_clk_cnt <= '0;
            for (int i = 0; i < sirb_pkg::NUM_CHANNELS; i++) begin
                r_chan_out[i] <= '0;
                r_chan_hi[i]  <= '0;
                r_chan_lo[i]  <= '0;
            end
            for (int i = 0; i < sirb_pkg::BUF_WORDS; i++) begin
                r_buf[i] <= sirb_pkg::BUF_RESET;
            end
        end else if (i_en) begin
            r_poll    <= n_poll;
            r_csr     <= n_csr;
            r_status  <= n_status;
            r_clk_cnt <= n_clk_cnt;
            if (w_buf_we) begin
                r_buf[i_dec.buf_idx] <= w_wd;
            end
            if (w_out_we) begin
                r_chan_out[i_dec.chan] <= w_wd;
            end
            if (w_hi_we) begin
                r_chan_hi[i_dec.chan] <= w_hi_data;
            end
            if (w_lo_we) begin
                r_chan_lo[i_dec.chan] <= w_lo_data;
            end
        end
    end

    assign o_mon.rdstint        = r_csr[sirb_pkg::CSR_RDSTINT_B];
    assign o_mon.rdst_any       = |(r_status & sirb_pkg::STAT_RDST);
    assign o_mon.csr_stuck_bits = r_csr[sirb_pkg::CSR_TSTART_B] | r_csr[sirb_pkg::CSR_COMERR_B];

endmodule

@@ sv/serial_interface_register_block_top.sv @@
// Serial interface register block, top level. Each word on the slave stream is
// one request: a bus read, a bus write (by byte offset) or a device data event
// for one channel; each request gives exactly one word on the master stream
// carrying the read data, the interrupt level after the request and the
// send-commands and transfer-start pulses. The block takes one request every
// clock cycle while the master side keeps up. When a result waits unaccepted
// the block takes at most one more request into its input register, then
// holds s_axis_tready low until the waiting result word is taken. A request
// accepted into the input register is decoded there; when it advances, which
// a waiting result can hold off, the register file updates and the result
// register loads its result word, which is then offered on the master stream.
// All state (channel out/in-high/in-low words, poll, control/status, status,
// clock count and the 32-word transfer buffer) is in flip-flops; the buffer
// comes out of reset as 0xcececece words.
// Depends on sirb_pkg, sirb_decode, sirb_regs and the assertion header.
`timescale 1ns / 1ps

module serial_interface_register_block_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: reg_offset[9:0], write_data[41:10], dev_channel[43:42],
    //        dev_has_data[44], dev_in_hi[76:45], dev_in_lo[108:77], zero fill
    input  logic [sirb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]   s_axis_tuser,
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: read_data[31:0], irq[32], send_commands[33], transfer_start[34],
    //        transfer_channel[36:35], transfer_in_length[44:37],
    //        transfer_out_length[52:45], zero fill
    output logic [sirb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // input register stage
    logic                r_s1_valid;
    sirb_pkg::t_sirb_req r_s1_req;

    // result register stage
    logic                r_out_valid;
    sirb_pkg::t_sirb_res r_out_res;

    sirb_pkg::t_sirb_dec w_dec;
    sirb_pkg::t_sirb_res w_res;
    sirb_pkg::t_sirb_mon w_mon;
    logic                w_adv;

    // the held request is processed when the result register is free or draining
    assign w_adv         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_req.req_type     <= sirb_pkg::t_req_kind'(s_axis_tuser);
            r_s1_req.reg_offset   <= s_axis_tdata[9:0];
            r_s1_req.write_data   <= s_axis_tdata[41:10];
            r_s1_req.dev_channel  <= s_axis_tdata[43:42];
            r_s1_req.dev_has_data <= s_axis_tdata[44];
            r_s1_req.dev_in_hi    <= s_axis_tdata[76:45];
            r_s1_req.dev_in_lo    <= s_axis_tdata[108:77];
        end
    end

    sirb_decode u_decode (
        .i_req (r_s1_req),
        .o_dec (w_dec)
    );

    // state only moves when a request is handed to the result register
    sirb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (r_s1_req),
        .i_dec   (w_dec),
        .o_res   (w_res),
        .o_mon   (w_mon)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000,
                            r_out_res.transfer_out_length,
                            r_out_res.transfer_in_length,
                            r_out_res.transfer_channel,
                            r_out_res.transfer_start,
                            r_out_res.send_commands,
                            r_out_res.irq,
                            r_out_res.read_data};

    `include "serial_interface_register_block_top_assert.svh"

    // the read-status interrupt flag always mirrors the per-channel ready bits
    `SIRB_ASSERT_ALWAYS(a_rdstint_tracks_rdst, w_mon.rdstint == w_mon.rdst_any,
        "rdstint flag out of step with channel ready bits")

    // start and error bits of the control word are never stored
    `SIRB_ASSERT_ALWAYS(a_csr_stuck_bits_clear, !w_mon.csr_stuck_bits,
        "control word holds a start or error bit")

    // without a start pulse the transfer fields stay zero, with one the lengths are set
    `SIRB_ASSERT_ALWAYS(a_transfer_fields,
        !r_out_valid ||
        (r_out_res.transfer_start ? (r_out_res.transfer_in_length != 8'd0 &&
                                     r_out_res.transfer_out_length != 8'd0)
                                  : (r_out_res.transfer_channel == 2'd0 &&
                                     r_out_res.transfer_in_length == 8'd0 &&
                                     r_out_res.transfer_out_length == 8'd0)),
        "transfer fields inconsistent with start pulse")

    // a held request that cannot move on is kept, not dropped
    `SIRB_ASSERT_NEXT(a_stalled_request_kept, r_s1_valid && !w_adv, r_s1_valid,
        "stalled request lost from input register")

endmodule

@@ tb/sv/tb_serial_interface_register_block_top.sv @@
// self-checking testbench for the serial interface register block top level
// depends on sirb_pkg and serial_interface_register_block_top; needs no files
`timescale 1ns / 1ps

module tb_serial_interface_register_block_top;

    import sirb_pkg::*;

    // buffer window and the tail of the run where neither side idles
    localparam logic [9:0] OFF_BUF_FIRST = 10'h080;
    localparam logic [9:0] OFF_BUF_LAST  = 10'h0FF;
    localparam int         RANDOM_WORDS  = 1200;
    localparam int         TAIL_WORDS    = 150;
    localparam int         HOLD_AT       = 400;
    localparam int         HOLD_CYCLES   = 250;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // tdata: reg_offset, write_data, dev_channel, dev_has_data, dev_in_hi, dev_in_lo
    logic [111:0] s_axis_tdata = '0;
    // tuser: req_type
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // tdata: read_data, irq, send_commands, transfer_start, transfer_channel,
    //        transfer_in_length, transfer_out_length
    logic [55:0]  m_axis_tdata;

    serial_interface_register_block_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shadow register file, starts in the post-reset state
    // ------------------------------------------------------------------
    logic [31:0] chan_out_q [4]  = '{default: '0};
    logic [31:0] chan_hi_q  [4]  = '{default: '0};
    logic [31:0] chan_lo_q  [4]  = '{default: '0};
    logic [31:0] xfer_buf_q [32] = '{default: BUF_RESET};
    logic [31:0] poll_q   = '0;
    logic [31:0] csr_q    = '0;
    logic [31:0] stat_q   = '0;
    logic [31:0] clkcnt_q = '0;

    t_sirb_req request_backlog [$];   // words still to be offered
    t_sirb_res due_results [$];       // predicted result words, oldest first
    t_sirb_req cur_req;               // word currently on the slave bus
    int        accepted_cnt = 0;
    int        sink_hold_left = 0;
    bit        hold_done = 1'b0;
    int        src_gap = 0;
    int        sink_gap = 0;
    int        bad_words = 0;

    // channel n keeps its data-ready flag in bit 5 of byte 3-n
    function automatic int rdst_at(input logic [1:0] ch);
        return 5 + 8 * (3 - int'(ch));
    endfunction

    // rdstint mirrors whether any channel has data ready
    function automatic void refresh_rdstint();
        csr_q[CSR_RDSTINT_B] = |(stat_q & STAT_RDST);
    endfunction

    function automatic logic [7:0] xfer_len(input logic [6:0] f);
        return (f == 7'd0) ? 8'd128 : 8'(f) + 8'd1;
    endfunction

    // apply one request word to the shadow registers and return its result word
    function automatic t_sirb_res regfile_access(input t_sirb_req rq);
        t_sirb_res  r;
        logic [9:0] off;
        logic [31:0] v;
        logic       wr;
        logic [1:0] ch;
        int         kind;
        r   = '0;
        off = rq.reg_offset;
        v   = rq.write_data;
        wr  = (rq.req_type == REQ_WRITE);
        if (rq.req_type == REQ_DEV) begin
            chan_hi_q[rq.dev_channel] = rq.dev_in_hi;
            chan_lo_q[rq.dev_channel] = rq.dev_in_lo;
            stat_q[rdst_at(rq.dev_channel)] = rq.dev_has_data;
            refresh_rdstint();
        end else if (rq.req_type == REQ_READ || rq.req_type == REQ_WRITE) begin
            if (off >= OFF_BUF_FIRST && off <= OFF_BUF_LAST) begin
                // low two offset bits dropped, 32 words wrap
                if (wr) xfer_buf_q[off[6:2]] = v;
                else r.read_data = xfer_buf_q[off[6:2]];
            end else if (off < OFF_POLL && off[1:0] == 2'b00) begin
                ch   = 2'(off / 12);
                kind = (off % 12) / 4;
                if (wr) begin
                    if (kind == 0) chan_out_q[ch] = v;
                    else if (kind == 1) chan_hi_q[ch] = v;
                    else chan_lo_q[ch] = v;
                end else if (kind == 0) begin
                    r.read_data = chan_out_q[ch];
                end else begin
                    // reading an input word drops that channel's data-ready flag
                    stat_q[rdst_at(ch)] = 1'b0;
                    refresh_rdstint();
                    r.read_data = (kind == 1) ? chan_hi_q[ch] : chan_lo_q[ch];
                end
            end else if (off == OFF_POLL) begin
                if (wr) poll_q = v; else r.read_data = poll_q;
            end else if (off == OFF_CSR) begin
                if (wr) begin
                    csr_q = (csr_q & CSR_KEEP) | (v & CSR_FIELDS);
                    if (v[CSR_RDSTINT_B]) csr_q[CSR_RDSTINT_B] = 1'b0;
                    if (v[CSR_TCINT_B]) csr_q[CSR_TCINT_B] = 1'b0;
                    if (v[CSR_TSTART_B]) begin
                        r.transfer_start      = 1'b1;
                        r.transfer_channel    = csr_q[2:1];
                        r.transfer_in_length  = xfer_len(csr_q[14:8]);
                        r.transfer_out_length = xfer_len(csr_q[22:16]);
                        csr_q[CSR_TCINT_B] = 1'b1;
                    end
                    refresh_rdstint();
                end else begin
                    r.read_data = csr_q;
                end
            end else if (off == OFF_STAT) begin
                if (wr) begin
                    // error bits stored as written, flag bits kept
                    stat_q = (stat_q & STAT_KEEP) | (v & STAT_ERR);
                    if (v[STAT_WR_B]) begin
                        r.send_commands = 1'b1;
                        stat_q = stat_q & ~STAT_WRST;
                    end
                end else begin
                    r.read_data = stat_q;
                end
            end else if (off == OFF_CLK) begin
                if (wr) clkcnt_q = v; else r.read_data = clkcnt_q;
            end else if (!wr) begin
                r.read_data = UNKNOWN_WORD;
            end
        end
        r.irq = (csr_q[CSR_RDSTINT_B] & csr_q[CSR_RDSTINTMSK_B]) |
                (csr_q[CSR_TCINT_B] & csr_q[CSR_TCINTMSK_B]);
        return r;
    endfunction

    function automatic t_sirb_req bus_word(input t_req_kind k, input logic [9:0] off,
                                           input logic [31:0] d);
        t_sirb_req rq;
        rq = '0;
        rq.req_type   = k;
        rq.reg_offset = off;
        rq.write_data = d;
        return rq;
    endfunction

    function automatic t_sirb_req dev_word(input logic [1:0] ch, input logic has,
                                           input logic [31:0] hi, input logic [31:0] lo);
        t_sirb_req rq;
        rq = '0;
        rq.req_type     = REQ_DEV;
        rq.dev_channel  = ch;
        rq.dev_has_data = has;
        rq.dev_in_hi    = hi;
        rq.dev_in_lo    = lo;
        return rq;
    endfunction

    // random word, weighted towards decoded registers, every field filled
    function automatic t_sirb_req random_word();
        t_sirb_req rq;
        int        pick;
        pick = $urandom_range(0, 99);
        rq.req_type = (pick < 38) ? REQ_READ : (pick < 76) ? REQ_WRITE :
                      (pick < 94) ? REQ_DEV : REQ_NONE;
        case ($urandom_range(0, 9))
            0, 1, 2: rq.reg_offset = 10'($urandom_range(0, 11) * 4);
            3:       rq.reg_offset = OFF_POLL;
            4:       rq.reg_offset = OFF_CSR;
            5:       rq.reg_offset = OFF_STAT;
            6:       rq.reg_offset = OFF_CLK;
            7, 8:    rq.reg_offset = OFF_BUF_FIRST + 10'($urandom_range(0, 127));
            default: rq.reg_offset = 10'($urandom);
        endcase
        case ($urandom_range(0, 15))
            0:       rq.write_data = '0;
            1:       rq.write_data = '1;
            default: rq.write_data = $urandom;
        endcase
        rq.dev_channel  = 2'($urandom);
        rq.dev_has_data = 1'($urandom);
        rq.dev_in_hi    = $urandom;
        rq.dev_in_lo    = $urandom;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers the backlog, predicts each word as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_results.push_back(regfile_access(cur_req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap = src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (request_backlog.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (request_backlog.size() > TAIL_WORDS && sink_hold_left == 0 &&
                             accepted_cnt % 300 < 200 && $urandom_range(0, 9) == 0) begin
                    // idle burst, this one included; src_gap counts the idle slots still to follow
                    src_gap = $urandom_range(0, 16);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    cur_req = request_backlog.pop_front();
                    s_axis_tdata  <= {3'b000, cur_req.dev_in_lo, cur_req.dev_in_hi,
                                      cur_req.dev_has_data, cur_req.dev_channel,
                                      cur_req.write_data, cur_req.reg_offset};
                    s_axis_tuser  <= cur_req.req_type;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // one long hold-off on the result side so the block backs up
    always @(posedge i_clk) begin
        if (!hold_done && accepted_cnt >= HOLD_AT) begin
            sink_hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (sink_hold_left != 0) begin
            sink_hold_left <= sink_hold_left - 1;
        end
    end

    // result-side ready with short random stalls, none near the end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (request_backlog.size() > TAIL_WORDS && accepted_cnt % 250 >= 60 &&
                     $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: every result word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sirb_res got;
        t_sirb_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.read_data           = m_axis_tdata[31:0];
            got.irq                 = m_axis_tdata[32];
            got.send_commands       = m_axis_tdata[33];
            got.transfer_start      = m_axis_tdata[34];
            got.transfer_channel    = m_axis_tdata[36:35];
            got.transfer_in_length  = m_axis_tdata[44:37];
            got.transfer_out_length = m_axis_tdata[52:45];
            if (due_results.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("%0t: result word %h with nothing due", $realtime, m_axis_tdata);
            end else begin
                want = due_results.pop_front();
                if (got.read_data !== want.read_data || got.irq !== want.irq ||
                    got.send_commands !== want.send_commands ||
                    got.transfer_start !== want.transfer_start ||
                    got.transfer_channel !== want.transfer_channel ||
                    got.transfer_in_length !== want.transfer_in_length ||
                    got.transfer_out_length !== want.transfer_out_length) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("%0t: expected rd=%h irq=%b snd=%b st=%b ch=%0d in=%0d out=%0d",
                                 $realtime, want.read_data, want.irq, want.send_commands,
                                 want.transfer_start, want.transfer_channel,
                                 want.transfer_in_length, want.transfer_out_length);
                        $display("%0t: actual   rd=%h irq=%b snd=%b st=%b ch=%0d in=%0d out=%0d",
                                 $realtime, got.read_data, got.irq, got.send_commands,
                                 got.transfer_start, got.transfer_channel,
                                 got.transfer_in_length, got.transfer_out_length);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // buffer reset pattern, aligned and unaligned buffer access, top word
        request_backlog.push_back(bus_word(REQ_READ, OFF_CSR, '0));
        request_backlog.push_back(bus_word(REQ_READ, OFF_BUF_FIRST, '0));
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_BUF_LAST, '1));
        request_backlog.push_back(bus_word(REQ_READ, 10'h0FC, '0));
        // channel 3 out word
        request_backlog.push_back(bus_word(REQ_WRITE, 10'h024, 32'hA5A5_5A5A));
        request_backlog.push_back(bus_word(REQ_READ, 10'h024, '0));
        // device data sets rdst, then masks on and a start with zero length fields (full 128 bytes)
        request_backlog.push_back(dev_word(2'd0, 1'b1, '1, '0));
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_CSR, 32'h4800_0007));
        request_backlog.push_back(bus_word(REQ_READ, OFF_CSR, '0));
        // reading the in-high word drops the data-ready flag
        request_backlog.push_back(bus_word(REQ_READ, 10'h004, '0));
        request_backlog.push_back(bus_word(REQ_READ, OFF_STAT, '0));
        // clear tcint together with a fresh start, full-scale and minimum lengths
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_CSR, 32'hFFFF_FFFF));
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_CSR, 32'h8001_0101));
        request_backlog.push_back(dev_word(2'd3, 1'b1, '0, '1));
        // status write with wr set sends commands, clears the wrst flags and keeps rdst
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_STAT, '1));
        request_backlog.push_back(bus_word(REQ_READ, OFF_STAT, '0));
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_STAT, '0));
        // unknown offsets: gap, top of range, unaligned, past the buffer
        request_backlog.push_back(bus_word(REQ_READ, 10'h040, '0));
        request_backlog.push_back(bus_word(REQ_READ, 10'h3FF, '0));
        request_backlog.push_back(bus_word(REQ_READ, 10'h002, '0));
        request_backlog.push_back(bus_word(REQ_WRITE, 10'h100, '1));
        request_backlog.push_back(bus_word(REQ_NONE, OFF_POLL, '1));
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_POLL, '1));
        request_backlog.push_back(bus_word(REQ_READ, OFF_POLL, '0));
        request_backlog.push_back(bus_word(REQ_WRITE, OFF_CLK, 32'h8000_0001));
        request_backlog.push_back(bus_word(REQ_READ, OFF_CLK, '0));
        repeat (RANDOM_WORDS) request_backlog.push_back(random_word());

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all words taken, then all results back, then a short drain
        while (request_backlog.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (bad_words == 0 && due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
